[rtl/pvfc_pkg.sv]
// Package for the pointer value frequency counter.
// Holds the shared types, codes and default constants; depends on nothing.
`timescale 1ns / 1ps
package pvfc_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int MAX_TOP_DEF  = 64;

  localparam int KEY_W   = 47;
  localparam int HIT_W   = 32;
  localparam int TOTAL_W = 48;
  localparam int DIST_W  = 11;
  localparam int TOP_W   = 7;
  localparam int RANK_W  = 6;
  localparam int IDX_W   = 2;

  localparam logic [KEY_W-1:0]   MIN_PTR_RESET = 47'h0000_0001_0000;
  localparam logic [KEY_W-1:0]   MAX_PTR_RESET = 47'h7FFE_FFFF_0000;
  localparam logic [TOP_W-1:0]   TOP_RESET     = 7'd10;
  localparam logic [DIST_W-1:0]  DISTINCT_MAX  = '1;
  localparam logic [HIT_W-1:0]   HIT_MAX       = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX     = '1;

  typedef enum logic [1:0] {
    OP_COUNT  = 2'd0,
    OP_REPORT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_PTR = 2'd0,
    REG_MAX_PTR = 2'd1,
    REG_TOP     = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_CMP,
    ST_CNT_END,
    ST_RPT_RD,
    ST_RPT_CMP,
    ST_RPT_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] word;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key_value;
    logic [HIT_W-1:0]   hits;
    logic [RANK_W-1:0]  rank;
    logic               entry_valid;
    logic [DIST_W-1:0]  distinct_keys;
    logic [TOTAL_W-1:0] words_seen;
    logic [TOTAL_W-1:0] hits_total;
    logic               table_overflow;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [HIT_W-1:0] hit;
  } entry_t;

  // True when entry a ranks ahead of entry b: larger count, then smaller key.
  function automatic logic ranks_ahead(entry_t a, entry_t b);
    return (a.hit > b.hit) || ((a.hit == b.hit) && (a.key < b.key));
  endfunction

endpackage

[rtl/pvfc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module pvfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/pointer_value_frequency_counter.sv]
// Top level of the pointer value frequency counter: control, totals and the table.
// Depends on pvfc_pkg and pvfc_ram.
`timescale 1ns / 1ps
// Counts 64-bit words that fall inside the pointer bounds in a table of CAPACITY
// keys with hit counts, and reports the top entries on request. A word outside
// the bounds and a clear are handled without leaving the idle state. A counted
// word scans the held keys one by one through the table memory, with a read state
// and a compare state per key read. A new key goes into the next free slot once
// every held key has been compared, if a slot is left. A report with n results
// makes n passes over the table, one result per pass; an empty table answers with
// a single beat. Results come one beat per strobe and cannot be held.
// Slots fill from the lowest address and are freed only by clear, so a fill count
// marks the used slots and no clearing pass is needed after reset.
module pointer_value_frequency_counter
  import pvfc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int MAX_TOP  = MAX_TOP_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cmd_t               cmd,
  output logic               result_valid,
  output result_t            result,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [KEY_W-1:0]   cfg_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int FW = AW + 1;

  state_t state, state_next;

  logic [KEY_W-1:0]   min_pointer;
  logic [KEY_W-1:0]   max_pointer;
  logic [TOP_W-1:0]   top_count;

  logic [FW-1:0]      fill;
  logic [TOTAL_W-1:0] seen_total;
  logic [TOTAL_W-1:0] counted_total;
  logic               overflow_flag;

  logic [AW-1:0]      idx;
  logic [KEY_W-1:0]   word_key;
  logic [TOP_W-1:0]   want_n;
  logic [TOP_W-1:0]   k;
  entry_t             best;
  entry_t             prev;
  logic               have_best;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  logic [AW-1:0]      ram_raddr;
  entry_t             ram_rdata;

  logic               accept;
  logic               in_range;
  logic               last_idx;
  logic               key_match;
  logic               cand_ok;
  logic [TOP_W-1:0]   want_clamped;
  logic [DIST_W-1:0]  distinct_sat;

  pvfc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign in_range = (cmd.word != 64'd0) &&
                    (cmd.word >= {17'd0, min_pointer}) &&
                    (cmd.word <= {17'd0, max_pointer});

  assign last_idx  = ({1'b0, idx} + FW'(1)) == fill;
  assign key_match = (ram_rdata.key == word_key);
  assign cand_ok   = (k == '0) || ranks_ahead(prev, ram_rdata);

  always_comb begin
    if (top_count == '0) begin
      want_clamped = TOP_W'(1);
    end else if (32'(top_count) > 32'(MAX_TOP)) begin
      want_clamped = TOP_W'(MAX_TOP);
    end else begin
      want_clamped = top_count;
    end
  end

  always_comb begin
    if (32'(fill) > 32'(DISTINCT_MAX)) begin
      distinct_sat = DISTINCT_MAX;
    end else begin
      distinct_sat = DIST_W'(fill);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (cmd.op == OP_COUNT) && in_range) begin
          state_next = (fill == '0) ? ST_CNT_END : ST_CNT_RD;
        end else if (accept && (cmd.op == OP_REPORT) && (fill != '0)) begin
          state_next = ST_RPT_RD;
        end
      end
      ST_CNT_RD:  state_next = ST_CNT_CMP;
      ST_CNT_CMP: begin
        if (key_match) begin
          state_next = ST_IDLE;
        end else if (last_idx) begin
          state_next = ST_CNT_END;
        end else begin
          state_next = ST_CNT_RD;
        end
      end
      ST_CNT_END: state_next = ST_IDLE;
      ST_RPT_RD:  state_next = ST_RPT_CMP;
      ST_RPT_CMP: state_next = last_idx ? ST_RPT_EMIT : ST_RPT_RD;
      ST_RPT_EMIT: begin
        state_next = ((k + TOP_W'(1)) == want_n) ? ST_IDLE : ST_RPT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Table memory controls.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = ram_rdata;
    ram_raddr = idx;
    unique case (state)
      ST_CNT_CMP: begin
        if (key_match && (ram_rdata.hit != HIT_MAX)) begin
          ram_we        = 1'b1;
          ram_wdata.hit = ram_rdata.hit + HIT_W'(1);
        end
      end
      ST_CNT_END: begin
        ram_waddr     = fill[AW-1:0];
        ram_wdata.key = word_key;
        ram_wdata.hit = HIT_W'(1);
        ram_we        = (32'(fill) < 32'(CAPACITY));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      min_pointer   <= MIN_PTR_RESET;
      max_pointer   <= MAX_PTR_RESET;
      top_count     <= TOP_RESET;
      fill          <= '0;
      seen_total    <= '0;
      counted_total <= '0;
      overflow_flag <= 1'b0;
      result_valid  <= 1'b0;
      idx           <= '0;
      k             <= '0;
      want_n        <= '0;
      have_best     <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;

      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MIN_PTR: min_pointer <= cfg_data;
          REG_MAX_PTR: max_pointer <= cfg_data;
          REG_TOP:     top_count   <= cfg_data[TOP_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          idx       <= '0;
          k         <= '0;
          have_best <= 1'b0;
          if (accept) begin
            case (op_t'(cmd.op))
              OP_COUNT: begin
                if (seen_total != TOTAL_MAX) begin
                  seen_total <= seen_total + TOTAL_W'(1);
                end
              end
              OP_REPORT: begin
                want_n <= (32'(fill) < 32'(want_clamped)) ? TOP_W'(fill) : want_clamped;
                if (fill == '0) begin
                  result_valid          <= 1'b1;
                  result.key_value      <= '0;
                  result.hits           <= '0;
                  result.rank           <= '0;
                  result.entry_valid    <= 1'b0;
                  result.distinct_keys  <= distinct_sat;
                  result.words_seen     <= seen_total;
                  result.hits_total     <= counted_total;
                  result.table_overflow <= overflow_flag;
                  result.last           <= 1'b1;
                end
              end
              OP_CLEAR: begin
                fill          <= '0;
                seen_total    <= '0;
                counted_total <= '0;
                overflow_flag <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_CNT_CMP: begin
          if (key_match && (ram_rdata.hit != HIT_MAX) && (counted_total != TOTAL_MAX)) begin
            counted_total <= counted_total + TOTAL_W'(1);
          end
          if (!key_match && !last_idx) begin
            idx <= idx + AW'(1);
          end
        end
        ST_CNT_END: begin
          if (32'(fill) < 32'(CAPACITY)) begin
            fill <= fill + FW'(1);
            if (counted_total != TOTAL_MAX) begin
              counted_total <= counted_total + TOTAL_W'(1);
            end
          end else begin
            overflow_flag <= 1'b1;
          end
        end
        ST_RPT_CMP: begin
          if (cand_ok && (!have_best || ranks_ahead(ram_rdata, best))) begin
            best      <= ram_rdata;
            have_best <= 1'b1;
          end
          if (!last_idx) begin
            idx <= idx + AW'(1);
          end
        end
        ST_RPT_EMIT: begin
          result_valid          <= 1'b1;
          result.key_value      <= best.key;
          result.hits           <= best.hit;
          result.rank           <= k[RANK_W-1:0];
          result.entry_valid    <= 1'b1;
          result.distinct_keys  <= distinct_sat;
          result.words_seen     <= seen_total;
          result.hits_total     <= counted_total;
          result.table_overflow <= overflow_flag;
          result.last           <= ((k + TOP_W'(1)) == want_n);
          prev      <= best;
          k         <= k + TOP_W'(1);
          idx       <= '0;
          have_best <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (cmd.op == OP_COUNT)) begin
      word_key <= cmd.word[KEY_W-1:0];
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= 32'(CAPACITY))
    else $error("table fill count beyond capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.op == OP_CLEAR)) |=> (fill == '0) && !overflow_flag)
    else $error("clear did not empty the table");

  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> busy)
    else $error("report stopped before its final beat");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.entry_valid) |-> result.last && (result.rank == '0))
    else $error("empty-table beat is not a lone final beat");

  a_emit_has_best: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RPT_EMIT) |-> have_best)
    else $error("report pass ended without a selected entry");

endmodule
